// ===== hw/rtl/lzhc_pkg.sv =====
// Shared types, constants and deflate code tables for the LZ77 hash chain tokenizer.
// No dependencies; imported by lzhc_token_enc and the core.
package lzhc_pkg;

    localparam int HEAD_ENTRIES = 256;
    localparam int HEAD_AW      = 8;
    localparam int LEN_CODES    = 29;
    localparam int DIST_CODES   = 30;
    localparam int DIST_W       = 16;

    localparam logic [8:0] LEN_SYM_BASE  = 9'd257;
    localparam logic [8:0] LEN_SYM_SPLIT = 9'd280;
    localparam logic [7:0] LIT_SPLIT     = 8'd144;

    // Configuration register indexes
    localparam logic CFG_CHAIN_LIMIT = 1'b0;
    localparam logic CFG_NICE_LENGTH = 1'b1;

    typedef struct packed {
        logic [7:0]  literal_byte;
        logic [8:0]  len_code;
        logic [4:0]  length_extra;
        logic [4:0]  dist_code;
        logic [12:0] distance_extra;
        logic [4:0]  token_bits;
    } tok_fields_t;

    function automatic logic [8:0] len_base(input logic [4:0] idx);
        logic [8:0] b;
        case (idx)
            5'd0:  b = 9'd3;
            5'd1:  b = 9'd4;
            5'd2:  b = 9'd5;
            5'd3:  b = 9'd6;
            5'd4:  b = 9'd7;
            5'd5:  b = 9'd8;
            5'd6:  b = 9'd9;
            5'd7:  b = 9'd10;
            5'd8:  b = 9'd11;
            5'd9:  b = 9'd13;
            5'd10: b = 9'd15;
            5'd11: b = 9'd17;
            5'd12: b = 9'd19;
            5'd13: b = 9'd23;
            5'd14: b = 9'd27;
            5'd15: b = 9'd31;
            5'd16: b = 9'd35;
            5'd17: b = 9'd43;
            5'd18: b = 9'd51;
            5'd19: b = 9'd59;
            5'd20: b = 9'd67;
            5'd21: b = 9'd83;
            5'd22: b = 9'd99;
            5'd23: b = 9'd115;
            5'd24: b = 9'd131;
            5'd25: b = 9'd163;
            5'd26: b = 9'd195;
            5'd27: b = 9'd227;
            5'd28: b = 9'd258;
            default: b = 9'd511;
        endcase
        return b;
    endfunction

    function automatic logic [4:0] len_xbits(input logic [4:0] idx);
        logic [4:0] x;
        if (idx < 5'd8 || idx == 5'd28)
        begin
            x = 5'd0;
        end
        else
        begin
            x = 5'((idx - 5'd4) >> 2);
        end
        return x;
    endfunction

    function automatic logic [14:0] dist_base(input logic [4:0] idx);
        logic [14:0] b;
        case (idx)
            5'd0:  b = 15'd1;
            5'd1:  b = 15'd2;
            5'd2:  b = 15'd3;
            5'd3:  b = 15'd4;
            5'd4:  b = 15'd5;
            5'd5:  b = 15'd7;
            5'd6:  b = 15'd9;
            5'd7:  b = 15'd13;
            5'd8:  b = 15'd17;
            5'd9:  b = 15'd25;
            5'd10: b = 15'd33;
            5'd11: b = 15'd49;
            5'd12: b = 15'd65;
            5'd13: b = 15'd97;
            5'd14: b = 15'd129;
            5'd15: b = 15'd193;
            5'd16: b = 15'd257;
            5'd17: b = 15'd385;
            5'd18: b = 15'd513;
            5'd19: b = 15'd769;
            5'd20: b = 15'd1025;
            5'd21: b = 15'd1537;
            5'd22: b = 15'd2049;
            5'd23: b = 15'd3073;
            5'd24: b = 15'd4097;
            5'd25: b = 15'd6145;
            5'd26: b = 15'd8193;
            5'd27: b = 15'd12289;
            5'd28: b = 15'd16385;
            5'd29: b = 15'd24577;
            default: b = 15'h7FFF;
        endcase
        return b;
    endfunction

    function automatic logic [4:0] dist_xbits(input logic [4:0] idx);
        logic [4:0] x;
        if (idx < 5'd4)
        begin
            x = 5'd0;
        end
        else
        begin
            x = 5'((idx - 5'd2) >> 1);
        end
        return x;
    endfunction

endpackage

// ===== hw/rtl/lzhc_token_enc.sv =====
// Token encoder: maps a literal or a length/distance pair to deflate symbols,
// extra bits and fixed-Huffman cost. Depends on lzhc_pkg.
module lzhc_token_enc (
    input  logic                        is_match,
    input  logic [7:0]                  literal,
    input  logic [8:0]                  match_len,
    input  logic [lzhc_pkg::DIST_W-1:0] match_dist,
    output lzhc_pkg::tok_fields_t       tok
);
    import lzhc_pkg::*;

    logic [4:0] li;
    logic [4:0] di;
    logic [4:0] lx;
    logic [4:0] dx;
    logic [8:0] sym;

    always_comb
    begin
        li = 5'd0;
        di = 5'd0;
        for (int i = 1; i < LEN_CODES; i++)
        begin
            if (match_len >= len_base(5'(i)))
            begin
                li = 5'(i);
            end
        end
        for (int j = 1; j < DIST_CODES; j++)
        begin
            if (match_dist >= DIST_W'(dist_base(5'(j))))
            begin
                di = 5'(j);
            end
        end
        lx  = len_xbits(li);
        dx  = dist_xbits(di);
        sym = LEN_SYM_BASE + 9'(li);

        tok = '0;
        if (is_match)
        begin
            tok.len_code        = sym;
            tok.length_extra    = 5'(match_len - len_base(li));
            tok.dist_code       = di;
            tok.distance_extra  = 13'(match_dist - DIST_W'(dist_base(di)));
            tok.token_bits      = ((sym < LEN_SYM_SPLIT) ? 5'd7 : 5'd8) + 5'd5 + lx + dx;
        end
        else
        begin
            tok.literal_byte = literal;
            tok.token_bits   = (literal < LIT_SPLIT) ? 5'd8 : 5'd9;
        end
    end

endmodule

// ===== hw/rtl/lz77_hash_chain_tokenizer_core.sv =====
// LZ77 hash chain tokenizer core: one pushed byte or flush step per transfer in,
// at most one deflate token per transfer out. Depends on lzhc_pkg, lzhc_token_enc.
//
// Bytes enter a history ring memory; once the lookahead holds LOOKAHEAD_SIZE bytes
// (or on a flush step) one position is processed. A byte push that does not fill
// the lookahead goes straight back to idle. A position covered by an earlier
// match is only inserted into its chain and gives no token. With the output free,
// a position with no chain search is encoded and emitted as a token. A search
// examines chain entries in turn, comparing bytes after the first in the single
// byte-compare loop on the two history read ports, and closes the walk at the
// chain limit, at a nil link or at a rejected entry; a match above the nice length
// ends the walk with no closing step. A flush that finds the lookahead empty
// returns block_done. The history, chain link and head memories need no clearing
// pass: the head table has one valid flop per entry, and chain and history
// entries are always written before they are read.
module lz77_hash_chain_tokenizer_core #(
    parameter int HISTORY_SIZE   = 32768,
    parameter int LOOKAHEAD_SIZE = 258
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic        s_tuser,   // command
    output logic        m_tvalid,
    input  logic        m_tready,
    // literal_byte[7:0], len_code[16:8], length_extra[21:17],
    // dist_code[26:22], distance_extra[39:27], token_bits[44:40],
    // total_bits[76:45], zero pad[79:77]
    output logic [79:0] m_tdata,
    output logic        m_tuser,   // is_match
    output logic        m_tlast,   // block_done
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [9:0]  cfg_wdata
);
    import lzhc_pkg::*;

    localparam int RING_DEPTH = HISTORY_SIZE + LOOKAHEAD_SIZE;
    localparam int PW = $clog2(RING_DEPTH);
    localparam int LW = $clog2(LOOKAHEAD_SIZE + 1);
    localparam int FW = $clog2(HISTORY_SIZE + 1);
    localparam logic [PW-1:0] RD_LAST = PW'(RING_DEPTH - 1);
    localparam logic [LW-1:0] LA_FULL = LW'(LOOKAHEAD_SIZE);
    localparam logic [FW-1:0] FILL_MAX = FW'(HISTORY_SIZE);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_GETC = 4'd1;
    localparam logic [3:0] S_HEAD = 4'd2;
    localparam logic [3:0] S_CAND = 4'd3;
    localparam logic [3:0] S_CHK  = 4'd4;
    localparam logic [3:0] S_CMP  = 4'd5;
    localparam logic [3:0] S_FIN  = 4'd6;
    localparam logic [3:0] S_TOK  = 4'd7;
    localparam logic [3:0] S_EMIT = 4'd8;
    localparam logic [3:0] S_DONE = 4'd9;

    function automatic logic [PW-1:0] ring_inc(input logic [PW-1:0] ptr);
        return (ptr == RD_LAST) ? '0 : ptr + 1'b1;
    endfunction

    // memories
    logic [7:0]    hist_mem [RING_DEPTH];
    logic [PW:0]   link_mem [RING_DEPTH];   // msb marks nil
    logic [PW-1:0] head_mem [HEAD_ENTRIES];
    logic [7:0]    hist_qa, hist_qb;
    logic [PW:0]   link_q;
    logic [PW-1:0] head_q;

    logic              hist_we;
    logic [PW-1:0]     hist_waddr, ra_addr, rb_addr;
    logic              link_we;
    logic [PW-1:0]     link_waddr, link_raddr;
    logic [PW:0]       link_wdata;
    logic              head_we;
    logic [HEAD_AW-1:0] head_waddr, head_raddr;

    // registers
    logic [3:0]    state_reg, state_next;
    logic [PW-1:0] cur_reg, cur_next, wp_reg, wp_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic [LW-1:0] la_reg, la_next, skip_reg, skip_next;
    logic [31:0]   total_reg, total_next;
    logic [9:0]    chain_limit_reg, chain_limit_next;
    logic [8:0]    nice_reg, nice_next;
    logic [HEAD_ENTRIES-1:0] head_vld_reg, head_vld_next;
    logic [7:0]    c_reg, c_next;
    logic [PW:0]   hold_reg, hold_next, p_reg, p_next, link_reg, link_next;
    logic [PW-1:0] d_reg, d_next, prev_reg, prev_next, best_d_reg, best_d_next;
    logic [PW-1:0] qa_reg, qa_next, qb_reg, qb_next;
    logic [9:0]    tries_reg, tries_next;
    logic [LW-1:0] best_len_reg, best_len_next, k_reg, k_next;
    logic          fin_match_reg, fin_match_next;
    logic [LW-1:0] fin_len_reg, fin_len_next;
    logic [PW-1:0] fin_d_reg, fin_d_next;
    tok_fields_t   tok_reg, tok_next, enc_tok;
    logic          out_valid_reg, out_valid_next, out_match_reg, out_match_next;
    logic          out_done_reg, out_done_next;
    logic [31:0]   out_total_reg, out_total_next;
    tok_fields_t   out_tok_reg, out_tok_next;

    logic          s_accept, out_free, do_adv, cmp_eq, cand_ok;
    logic [PW:0]   adv_link, head_sel;
    logic [LW-1:0] la_after, k1, cand_len;

    lzhc_token_enc u_enc (
        .is_match   (fin_match_reg),
        .literal    (c_reg),
        .match_len  (9'(fin_len_reg)),
        .match_dist (DIST_W'(fin_d_reg)),
        .tok        (enc_tok)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_match_reg;
    assign m_tlast  = out_done_reg;
    assign m_tdata  = {3'b000, out_total_reg, out_tok_reg.token_bits,
                       out_tok_reg.distance_extra, out_tok_reg.dist_code,
                       out_tok_reg.length_extra, out_tok_reg.len_code,
                       out_tok_reg.literal_byte};

    assign head_sel = head_vld_reg[c_reg] ? {1'b0, head_q} : {1'b1, {PW{1'b0}}};
    assign la_after = (la_reg < LA_FULL) ? la_reg + 1'b1 : la_reg;
    assign cmp_eq   = (hist_qa == hist_qb);
    assign k1       = k_reg + 1'b1;
    assign cand_len = cmp_eq ? k1 : k_reg;
    assign cand_ok  = (cand_len >= LW'(3));

    always_comb
    begin
        state_next       = state_reg;
        cur_next         = cur_reg;
        wp_next          = wp_reg;
        fill_next        = fill_reg;
        la_next          = la_reg;
        skip_next        = skip_reg;
        total_next       = total_reg;
        chain_limit_next = chain_limit_reg;
        nice_next        = nice_reg;
        head_vld_next    = head_vld_reg;
        c_next           = c_reg;
        hold_next        = hold_reg;
        p_next           = p_reg;
        link_next        = link_reg;
        d_next           = d_reg;
        prev_next        = prev_reg;
        best_d_next      = best_d_reg;
        qa_next          = qa_reg;
        qb_next          = qb_reg;
        tries_next       = tries_reg;
        best_len_next    = best_len_reg;
        k_next           = k_reg;
        fin_match_next   = fin_match_reg;
        fin_len_next     = fin_len_reg;
        fin_d_next       = fin_d_reg;
        tok_next         = tok_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        out_match_next   = out_match_reg;
        out_done_next    = out_done_reg;
        out_total_next   = out_total_reg;
        out_tok_next     = out_tok_reg;

        hist_we    = 1'b0;
        hist_waddr = wp_reg;
        ra_addr    = cur_reg;
        rb_addr    = cur_reg;
        link_raddr = p_reg[PW-1:0];
        head_raddr = hist_qa;
        do_adv     = 1'b0;
        adv_link   = hold_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CHAIN_LIMIT: chain_limit_next = cfg_wdata;
                CFG_NICE_LENGTH: nice_next = cfg_wdata[8:0];
                default: ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_accept)
                begin
                    if (!s_tuser)
                    begin
                        if (la_reg < LA_FULL)
                        begin
                            hist_we = 1'b1;
                            wp_next = ring_inc(wp_reg);
                            la_next = la_after;
                        end
                        if (la_after == LA_FULL)
                        begin
                            state_next = S_GETC;
                        end
                    end
                    else if (la_reg == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_GETC;
                    end
                end
            end
            S_GETC:
            begin
                c_next     = hist_qa;
                state_next = S_HEAD;
            end
            S_HEAD:
            begin
                hold_next = head_sel;
                if (skip_reg != '0)
                begin
                    // covered by the previous match: insert only
                    adv_link   = head_sel;
                    do_adv     = 1'b1;
                    skip_next  = skip_reg - 1'b1;
                    state_next = S_IDLE;
                end
                else if (fill_reg == '0 || la_reg < LW'(3))
                begin
                    fin_match_next = 1'b0;
                    state_next     = S_TOK;
                end
                else
                begin
                    p_next        = head_sel;
                    tries_next    = chain_limit_reg;
                    prev_next     = '0;
                    best_len_next = '0;
                    best_d_next   = '0;
                    state_next    = S_CAND;
                end
            end
            S_CAND:
            begin
                if (tries_reg == '0 || p_reg[PW])
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    ra_addr = p_reg[PW-1:0];
                    if (cur_reg >= p_reg[PW-1:0])
                    begin
                        d_next = cur_reg - p_reg[PW-1:0];
                    end
                    else
                    begin
                        d_next = PW'({1'b0, cur_reg} + (PW+1)'(RING_DEPTH) - p_reg);
                    end
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                if (hist_qa != c_reg || d_reg == '0 ||
                    32'(d_reg) > 32'(HISTORY_SIZE) || 32'(d_reg) > 32'(fill_reg) ||
                    d_reg <= prev_reg)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    prev_next  = d_reg;
                    link_next  = link_q;
                    ra_addr    = ring_inc(p_reg[PW-1:0]);
                    rb_addr    = ring_inc(cur_reg);
                    qa_next    = ring_inc(ring_inc(p_reg[PW-1:0]));
                    qb_next    = ring_inc(ring_inc(cur_reg));
                    k_next     = LW'(1);
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                ra_addr = qa_reg;
                rb_addr = qb_reg;
                qa_next = ring_inc(qa_reg);
                qb_next = ring_inc(qb_reg);
                k_next  = k1;
                if (!(cmp_eq && k1 < LA_FULL && k1 < la_reg))
                begin
                    if (cand_ok && 32'(cand_len) > 32'(nice_reg))
                    begin
                        fin_match_next = 1'b1;
                        fin_len_next   = cand_len;
                        fin_d_next     = d_reg;
                        state_next     = S_TOK;
                    end
                    else
                    begin
                        if (cand_ok && cand_len > best_len_reg)
                        begin
                            best_len_next = cand_len;
                            best_d_next   = d_reg;
                        end
                        p_next     = link_reg;
                        tries_next = tries_reg - 1'b1;
                        state_next = S_CAND;
                    end
                end
            end
            S_FIN:
            begin
                fin_match_next = (best_len_reg != '0);
                fin_len_next   = best_len_reg;
                fin_d_next     = best_d_reg;
                state_next     = S_TOK;
            end
            S_TOK:
            begin
                tok_next   = enc_tok;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_match_next = fin_match_reg;
                    out_done_next  = 1'b0;
                    out_tok_next   = tok_reg;
                    total_next     = total_reg + 32'(tok_reg.token_bits);
                    out_total_next = total_next;
                    skip_next      = fin_match_reg ? fin_len_reg - 1'b1 : '0;
                    do_adv         = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_match_next = 1'b0;
                    out_done_next  = 1'b1;
                    out_tok_next   = '0;
                    out_total_next = total_reg;
                    total_next     = '0;
                    skip_next      = '0;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        // insert current position into its chain and advance
        link_we    = do_adv;
        link_waddr = cur_reg;
        link_wdata = adv_link;
        head_we    = do_adv;
        head_waddr = c_reg;
        if (do_adv)
        begin
            head_vld_next[c_reg] = 1'b1;
            cur_next = ring_inc(cur_reg);
            if (la_reg != '0)
            begin
                la_next = la_reg - 1'b1;
            end
            if (fill_reg < FILL_MAX)
            begin
                fill_next = fill_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (hist_we)
        begin
            hist_mem[hist_waddr] <= s_tdata;
        end
        hist_qa <= hist_mem[ra_addr];
        hist_qb <= hist_mem[rb_addr];
    end

    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
        link_q <= link_mem[link_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (head_we)
        begin
            head_mem[head_waddr] <= cur_reg;
        end
        head_q <= head_mem[head_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            cur_reg         <= '0;
            wp_reg          <= '0;
            fill_reg        <= '0;
            la_reg          <= '0;
            skip_reg        <= '0;
            total_reg       <= '0;
            chain_limit_reg <= 10'd500;
            nice_reg        <= 9'd50;
            head_vld_reg    <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cur_reg         <= cur_next;
            wp_reg          <= wp_next;
            fill_reg        <= fill_next;
            la_reg          <= la_next;
            skip_reg        <= skip_next;
            total_reg       <= total_next;
            chain_limit_reg <= chain_limit_next;
            nice_reg        <= nice_next;
            head_vld_reg    <= head_vld_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        c_reg          <= c_next;
        hold_reg       <= hold_next;
        p_reg          <= p_next;
        link_reg       <= link_next;
        d_reg          <= d_next;
        prev_reg       <= prev_next;
        best_d_reg     <= best_d_next;
        qa_reg         <= qa_next;
        qb_reg         <= qb_next;
        tries_reg      <= tries_next;
        best_len_reg   <= best_len_next;
        k_reg          <= k_next;
        fin_match_reg  <= fin_match_next;
        fin_len_reg    <= fin_len_next;
        fin_d_reg      <= fin_d_next;
        tok_reg        <= tok_next;
        out_match_reg  <= out_match_next;
        out_done_reg   <= out_done_next;
        out_total_reg  <= out_total_next;
        out_tok_reg    <= out_tok_next;
    end

    a_la_bound: assert property (@(posedge clk) disable iff (!rst_n)
        la_reg <= LA_FULL)
        else $error("lookahead count above its size");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_MAX)
        else $error("history fill above history size");

    a_done_no_match: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> !m_tuser)
        else $error("block end marked as a match");

    a_skip_idle_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_HEAD && skip_reg != '0) |=> (state_reg == S_IDLE && !$rose(m_tvalid)))
        else $error("covered position produced a token");

endmodule
